@@ hw/rtl/bmp24_pkg.sv @@
// Shared types and constants for the 24-bit BMP stream decoder.
// Used by the parser, the top level and the port checker; depends on nothing.

package bmp24_pkg;

   localparam int unsigned HEADER_BYTES = 54;
   localparam logic [31:0] MAX_DIM = 32'd4096;
   localparam logic [15:0] BMP_MAGIC_WORD = 16'h424D;
   localparam logic [15:0] DEPTH_24_BPP = 16'd24;

   localparam logic [5:0] POS_SIG_HI = 6'd0;
   localparam logic [5:0] POS_SIG_LO = 6'd1;
   localparam logic [5:0] POS_OFFS_0 = 6'd10;
   localparam logic [5:0] POS_OFFS_1 = 6'd11;
   localparam logic [5:0] POS_OFFS_2 = 6'd12;
   localparam logic [5:0] POS_OFFS_3 = 6'd13;
   localparam logic [5:0] POS_WIDTH_0 = 6'd18;
   localparam logic [5:0] POS_WIDTH_1 = 6'd19;
   localparam logic [5:0] POS_WIDTH_2 = 6'd20;
   localparam logic [5:0] POS_WIDTH_3 = 6'd21;
   localparam logic [5:0] POS_HEIGHT_0 = 6'd22;
   localparam logic [5:0] POS_HEIGHT_1 = 6'd23;
   localparam logic [5:0] POS_HEIGHT_2 = 6'd24;
   localparam logic [5:0] POS_HEIGHT_3 = 6'd25;
   localparam logic [5:0] POS_DEPTH_0 = 6'd28;
   localparam logic [5:0] POS_DEPTH_1 = 6'd29;
   localparam logic [5:0] POS_HEADER_END = 6'(HEADER_BYTES - 1);

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_SKIP   = 5'b00010,
      PH_PIXEL  = 5'b00100,
      PH_PAD    = 5'b01000,
      PH_DONE   = 5'b10000
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [11:0] column;
      logic [11:0] row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        last_pixel;
      logic        signature_bad;
      logic        depth_unsupported;
      logic        size_unsupported;
   } result_type;

   function automatic logic dim_bad(input logic [31:0] v);
      return (v == 32'd0) || v[31] || (v > MAX_DIM);
   endfunction

endpackage

@@ hw/rtl/bmp24_parser.sv @@
// Byte-level parser: header capture, offset skip, pixel assembly and row padding.
// Depends on bmp24_pkg. Produces at most one result per transfer, combinationally.

module bmp24_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               data_byte,
   input  logic                     start_of_file,
   output logic                     res_valid,
   output bmp24_pkg::result_type    res
);

   bmp24_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [31:0] pos_ff, pos_in, pos_cur;
   logic [15:0] sig_ff, sig_in, sig_cur;
   logic [31:0] offs_ff, offs_in, offs_cur;
   logic [31:0] width_ff, width_in, width_cur;
   logic [31:0] height_ff, height_in, height_cur;
   logic [15:0] bpp_ff, bpp_in, bpp_cur;
   logic [11:0] col_ff, col_in, col_cur;
   logic [11:0] row_ff, row_in, row_cur;
   logic [1:0]  bip_ff, bip_in, bip_cur;
   logic [1:0]  pad_ff, pad_in, pad_cur;
   logic [7:0]  blue_ff, green_ff;
   logic        in_header;
   logic        size_bad;
   logic        row_end;
   logic        last;

   always_comb begin
      phase_cur  = start_of_file ? bmp24_pkg::PH_HEADER : phase_ff;
      pos_cur    = start_of_file ? 32'd0 : pos_ff;
      sig_cur    = start_of_file ? 16'd0 : sig_ff;
      offs_cur   = start_of_file ? 32'd0 : offs_ff;
      width_cur  = start_of_file ? 32'd0 : width_ff;
      height_cur = start_of_file ? 32'd0 : height_ff;
      bpp_cur    = start_of_file ? 16'd0 : bpp_ff;
      col_cur    = start_of_file ? 12'd0 : col_ff;
      row_cur    = start_of_file ? 12'd0 : row_ff;
      bip_cur    = start_of_file ? 2'd0 : bip_ff;
      pad_cur    = start_of_file ? 2'd0 : pad_ff;

      pos_in    = (pos_cur == 32'hFFFF_FFFF) ? pos_cur : pos_cur + 32'd1;
      phase_in  = phase_cur;
      sig_in    = sig_cur;
      offs_in   = offs_cur;
      width_in  = width_cur;
      height_in = height_cur;
      bpp_in    = bpp_cur;
      col_in    = col_cur;
      row_in    = row_cur;
      bip_in    = bip_cur;
      pad_in    = pad_cur;

      in_header = (pos_cur[31:6] == 26'd0);
      size_bad  = bmp24_pkg::dim_bad(width_cur) || bmp24_pkg::dim_bad(height_cur);
      row_end   = ({1'b0, col_cur} + 13'd1) >= width_cur[12:0];
      last      = row_end && (row_cur == 12'd0);

      res_valid = 1'b0;
      res       = '0;

      unique case (phase_cur)
         bmp24_pkg::PH_HEADER: begin
            if (in_header) begin
               case (pos_cur[5:0])
                  bmp24_pkg::POS_SIG_HI:   sig_in[15:8]     = data_byte;
                  bmp24_pkg::POS_SIG_LO:   sig_in[7:0]      = data_byte;
                  bmp24_pkg::POS_OFFS_0:   offs_in[7:0]     = data_byte;
                  bmp24_pkg::POS_OFFS_1:   offs_in[15:8]    = data_byte;
                  bmp24_pkg::POS_OFFS_2:   offs_in[23:16]   = data_byte;
                  bmp24_pkg::POS_OFFS_3:   offs_in[31:24]   = data_byte;
                  bmp24_pkg::POS_WIDTH_0:  width_in[7:0]    = data_byte;
                  bmp24_pkg::POS_WIDTH_1:  width_in[15:8]   = data_byte;
                  bmp24_pkg::POS_WIDTH_2:  width_in[23:16]  = data_byte;
                  bmp24_pkg::POS_WIDTH_3:  width_in[31:24]  = data_byte;
                  bmp24_pkg::POS_HEIGHT_0: height_in[7:0]   = data_byte;
                  bmp24_pkg::POS_HEIGHT_1: height_in[15:8]  = data_byte;
                  bmp24_pkg::POS_HEIGHT_2: height_in[23:16] = data_byte;
                  bmp24_pkg::POS_HEIGHT_3: height_in[31:24] = data_byte;
                  bmp24_pkg::POS_DEPTH_0:  bpp_in[7:0]      = data_byte;
                  bmp24_pkg::POS_DEPTH_1:  bpp_in[15:8]     = data_byte;
                  default: ;
               endcase
               if (pos_cur[5:0] == bmp24_pkg::POS_HEADER_END) begin
                  res_valid             = 1'b1;
                  res.kind              = bmp24_pkg::KIND_REPORT;
                  res.signature_bad     = (sig_cur != bmp24_pkg::BMP_MAGIC_WORD);
                  res.depth_unsupported = (bpp_cur != bmp24_pkg::DEPTH_24_BPP);
                  res.size_unsupported  = size_bad;
                  col_in = 12'd0;
                  row_in = size_bad ? 12'd0 : height_cur[11:0] - 12'd1;
                  bip_in = 2'd0;
                  if (size_bad) begin
                     phase_in = bmp24_pkg::PH_DONE;
                  end else if (offs_cur > 32'(bmp24_pkg::HEADER_BYTES)) begin
                     phase_in = bmp24_pkg::PH_SKIP;
                  end else begin
                     phase_in = bmp24_pkg::PH_PIXEL;
                  end
               end
            end
         end
         bmp24_pkg::PH_SKIP: begin
            if (pos_in >= offs_cur) begin
               phase_in = bmp24_pkg::PH_PIXEL;
            end
         end
         bmp24_pkg::PH_PIXEL: begin
            if (bip_cur == 2'd0) begin
               bip_in = 2'd1;
            end else if (bip_cur == 2'd1) begin
               bip_in = 2'd2;
            end else begin
               bip_in         = 2'd0;
               res_valid      = 1'b1;
               res.kind       = bmp24_pkg::KIND_PIXEL;
               res.column     = col_cur;
               res.row        = row_cur;
               res.red        = data_byte;
               res.green      = green_ff;
               res.blue       = blue_ff;
               res.last_pixel = last;
               if (last) begin
                  phase_in = bmp24_pkg::PH_DONE;
               end else if (row_end) begin
                  col_in = 12'd0;
                  row_in = row_cur - 12'd1;
                  pad_in = width_cur[1:0];
                  if (width_cur[1:0] != 2'd0) begin
                     phase_in = bmp24_pkg::PH_PAD;
                  end
               end else begin
                  col_in = col_cur + 12'd1;
               end
            end
         end
         bmp24_pkg::PH_PAD: begin
            pad_in = (pad_cur != 2'd0) ? pad_cur - 2'd1 : pad_cur;
            if (pad_in == 2'd0) begin
               phase_in = bmp24_pkg::PH_PIXEL;
            end
         end
         bmp24_pkg::PH_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bmp24_pkg::PH_HEADER;
         pos_ff    <= 32'd0;
         sig_ff    <= 16'd0;
         offs_ff   <= 32'd0;
         width_ff  <= 32'd0;
         height_ff <= 32'd0;
         bpp_ff    <= 16'd0;
         col_ff    <= 12'd0;
         row_ff    <= 12'd0;
         bip_ff    <= 2'd0;
         pad_ff    <= 2'd0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         sig_ff    <= sig_in;
         offs_ff   <= offs_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         bpp_ff    <= bpp_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         bip_ff    <= bip_in;
         pad_ff    <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_cur == bmp24_pkg::PH_PIXEL)) begin
         if (bip_cur == 2'd0) begin
            blue_ff <= data_byte;
         end
         if (bip_cur == 2'd1) begin
            green_ff <= data_byte;
         end
      end
   end

endmodule

@@ hw/rtl/bmp24_stream_decoder_core.sv @@
// Top level of the 24-bit BMP stream decoder: stream ports, result register and skid stage.
// Depends on bmp24_pkg and bmp24_parser.

// The block takes one file byte per transfer and can take a byte in every cycle while
// req_tready is high; each byte is handled by the single pass of counter compares and
// field capture between the parser's state registers and the result register. A result
// is registered in the result register, or in the skid stage while the rsp side stalls,
// from the byte that causes it: one header report after byte 53 (rsp_tuser high, three
// flags in rsp_tdata), then one pixel per B,G,R triple, bottom row first, with rsp_tlast
// on the final pixel. A one-entry skid stage behind the result register keeps req_tready
// high while a single result waits; req_tready falls only when two results are held.
// Setting req_tuser on a byte restarts parsing with that byte as byte 0 of a new file.

module bmp24_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [11:0] column, [23:12] row, [31:24] red,
                                    // [39:32] green, [47:40] blue, [48] signature_bad,
                                    // [49] depth_unsupported, [50] size_unsupported,
                                    // [55:51] zero
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast    // last_pixel
);

   logic                   accept;
   logic                   new_valid;
   bmp24_pkg::result_type  new_res;
   logic                   out_valid_ff, out_valid_in;
   bmp24_pkg::result_type  out_ff, out_in;
   logic                   skid_valid_ff, skid_valid_in;
   bmp24_pkg::result_type  skid_ff, skid_in;
   logic                   out_take;

   assign req_tready = !skid_valid_ff;
   assign accept     = req_tvalid && req_tready;

   bmp24_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_tdata),
      .start_of_file (req_tuser),
      .res_valid     (new_valid),
      .res           (new_res)
   );

   assign out_take = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept && new_valid;
            out_in       = new_res;
         end
      end else if (accept && new_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = new_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last_pixel;
   assign rsp_tdata  = {5'd0, out_ff.size_unsupported, out_ff.depth_unsupported,
                        out_ff.signature_bad, out_ff.blue, out_ff.green, out_ff.red,
                        out_ff.row, out_ff.column};

endmodule

@@ hw/rtl/bmp24_checker.sv @@
// Port-level checker for the BMP stream decoder, attached to the top level by bind.
// Depends on bmp24_pkg for the result kind codes.

module bmp24_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result channel is valid right after reset.");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("A stalled result transfer changed or vanished.");

   a_report_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bmp24_pkg::KIND_REPORT) |-> !rsp_tlast
         && (rsp_tdata[47:0] == 48'd0))
      else $error("A header report carries pixel data or the last marker.");

   a_pixel_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == bmp24_pkg::KIND_PIXEL) |-> (rsp_tdata[55:48] == 8'd0))
      else $error("A pixel result carries header flags.");

endmodule

bind bmp24_stream_decoder_core bmp24_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
